// ===== src/poc_pkg.sv =====
// Shared definitions for the pattern occurrence counter: defaults, register
// indexes, the record passed from front to back, and the length clamp.
// No dependencies.
`default_nettype none

package poc_pkg;

   // Default sizes handed to the top level's parameters.
   localparam int MAX_PATTERN_DEFAULT    = 16;
   localparam int SEGMENT_BUFFER_DEFAULT = 256;

   // Depth of the record queue between front and back.
   localparam int REC_QUEUE_DEPTH = 2;

   // The pattern registers hold sixteen bytes; bytes beyond them read as zero.
   localparam int PATTERN_REG_BYTES = 16;

   // Width of the register index on the configuration port.
   localparam int CSR_INDEX_W = 2;

   // Byte that closes a segment.
   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_PATTERN_LENGTH = 2'd2
   } csr_index_type;

   // What the front has learnt about one item.
   typedef struct packed {
      logic present;   // the item carried a text byte
      logic hit;       // the window ends in a full match of the pattern
      logic seg_end;   // this byte closes the current segment
      logic eot;       // end of text: deliver the count
   } rec_type;

   // Pattern length in use: the register value, capped at the window depth.
   function automatic logic [7:0] effective_length(input logic [4:0] len,
                                                   input int max_pattern);
      logic [7:0] wide;
      logic [7:0] cap;
      wide = {3'b000, len};
      cap  = 8'(max_pattern);
      return (wide > cap) ? cap : wide;
   endfunction

endpackage

`default_nettype wire

// ===== src/poc_front.sv =====
// Front end of the pattern occurrence counter: keeps the window of recent
// bytes and the segment fill, and compares the window against the pattern.
// Depends on poc_pkg.
`default_nettype none

module poc_front #(
   parameter int MAX_PATTERN    = poc_pkg::MAX_PATTERN_DEFAULT,
   parameter int SEGMENT_BUFFER = poc_pkg::SEGMENT_BUFFER_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [63:0]      pattern_low,
   input  logic [63:0]      pattern_high,
   input  logic [4:0]       pattern_length,
   input  logic             item_valid,
   input  logic [7:0]       data_byte,
   input  logic             byte_present,
   input  logic             end_of_text,
   output logic             rec_push,
   output poc_pkg::rec_type rec
);
   import poc_pkg::*;

   localparam int FILL_W   = $clog2(SEGMENT_BUFFER);
   localparam int CMP_W    = (FILL_W > 8) ? FILL_W : 8;
   localparam int SEG_LAST = SEGMENT_BUFFER - 1;

   logic [7:0]        window_ff [MAX_PATTERN];
   logic [7:0]        window_in [MAX_PATTERN];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [FILL_W-1:0] fill_next;
   logic [7:0]        len_eff;
   logic [7:0]        pattern_bytes [PATTERN_REG_BYTES];
   logic [MAX_PATTERN-1:0] lane_ok;
   logic              hit;
   logic              seg_end;

   // Unpack the two pattern registers into bytes, first byte lowest.
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         pattern_bytes[j]     = pattern_low[8*j +: 8];
         pattern_bytes[j + 8] = pattern_high[8*j +: 8];
      end
   end

   assign len_eff = effective_length(pattern_length, MAX_PATTERN);

   // The window after this byte: newest at position zero.
   always_comb begin
      window_in[0] = data_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   // Each window position is held against the pattern byte that lines up with
   // it for the current length; positions beyond the length always pass.
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_lane
      logic [7:0] src;
      logic [7:0] expected;
      assign src      = len_eff - 8'(k + 1);
      assign expected = (src < 8'(PATTERN_REG_BYTES)) ? pattern_bytes[src[3:0]] : 8'h00;
      assign lane_ok[k] = (8'(k) >= len_eff) || (window_in[k] == expected);
   end

   // A match needs a non-zero length and enough bytes in the segment.
   assign fill_next = fill_ff + 1'b1;
   assign hit       = (len_eff != 8'd0) && (CMP_W'(fill_next) >= CMP_W'(len_eff)) && (&lane_ok);
   assign seg_end   = (data_byte == NEWLINE_BYTE) || (fill_next >= FILL_W'(SEG_LAST));

   // Record for the back end; empty items carry nothing and are dropped.
   always_comb begin
      rec.present = byte_present;
      rec.hit     = byte_present && hit;
      rec.seg_end = byte_present && seg_end;
      rec.eot     = end_of_text;
      rec_push    = item_valid && (byte_present || end_of_text);
   end

   // Segment fill restarts at a segment end and at the end of the text.
   always_comb begin
      fill_in = fill_ff;
      if (item_valid) begin
         if (end_of_text || (byte_present && seg_end)) begin
            fill_in = '0;
         end else if (byte_present) begin
            fill_in = fill_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Only positions below the fill are ever compared, so the window needs no reset.
   always_ff @(posedge clock) begin
      if (item_valid && byte_present) begin
         window_ff <= window_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/poc_queue.sv =====
// Short record queue between the front and back of the pattern occurrence
// counter. Depends on poc_pkg.
`default_nettype none

module poc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  poc_pkg::rec_type push_rec,
   output logic             full,
   input  logic             pop,
   output poc_pkg::rec_type pop_rec,
   output logic             empty
);
   import poc_pkg::*;

   localparam int PTR_W   = (REC_QUEUE_DEPTH > 1) ? $clog2(REC_QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(REC_QUEUE_DEPTH + 1);

   rec_type            entry_ff [REC_QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (count_ff == COUNT_W'(REC_QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_rec = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(REC_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(REC_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

`default_nettype wire

// ===== src/poc_back.sv =====
// Back end of the pattern occurrence counter: applies the overlap rule,
// keeps the saturating count and holds the result for the consumer.
// Depends on poc_pkg.
`default_nettype none

module poc_back #(
   parameter int MAX_PATTERN = poc_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [4:0]       pattern_length,
   input  logic             rec_valid,
   input  poc_pkg::rec_type rec,
   output logic             rec_take,
   input  logic             pop,
   output logic             empty,
   output logic [31:0]      match_count
);
   import poc_pkg::*;

   localparam int SKIP_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [SKIP_W-1:0] skip_ff;
   logic [SKIP_W-1:0] skip_in;
   logic [31:0]       count_ff;
   logic [31:0]       count_in;
   logic [31:0]       count_step;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [31:0]       rsp_count_ff;
   logic [31:0]       rsp_count_in;
   logic [7:0]        len_eff;
   logic              rsp_pop;

   assign len_eff     = effective_length(pattern_length, MAX_PATTERN);
   assign rsp_pop     = pop && rsp_valid_ff;
   assign empty       = !rsp_valid_ff;
   assign match_count = rsp_count_ff;

   // An end-of-text record waits only while the previous count is still held.
   assign rec_take = rec_valid && (!rec.eot || !rsp_valid_ff || rsp_pop);

   // Overlap skip and counting for one record.
   always_comb begin
      skip_in    = skip_ff;
      count_step = count_ff;
      if (rec_take && rec.present) begin
         if (skip_ff != '0) begin
            skip_in = skip_ff - 1'b1;
         end else if (rec.hit) begin
            if (count_ff != 32'hFFFF_FFFF) begin
               count_step = count_ff + 32'd1;
            end
            skip_in = SKIP_W'(len_eff - 8'd1);
         end
      end
      if (rec_take && rec.seg_end) begin
         skip_in = '0;
      end
      count_in = count_step;
      if (rec_take && rec.eot) begin
         skip_in  = '0;
         count_in = '0;
      end
   end

   // Result register: loaded at end of text, freed by the consumer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_count_in = rsp_count_ff;
      if (rec_take && rec.eot) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = count_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         skip_ff      <= skip_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
   end

endmodule

`default_nettype wire

// ===== src/pattern_occurrence_counter.sv =====
// Top level of the pattern occurrence counter: configuration registers and
// the front, record queue and back. Depends on poc_pkg, poc_front, poc_queue
// and poc_back.
`default_nettype none

// Counts leftmost, non-overlapping occurrences of a pattern of up to
// MAX_PATTERN bytes in a text fed one byte per transfer. Segments end after a
// newline or after SEGMENT_BUFFER-1 bytes and no match spans a segment end.
// The count of the whole text, saturated at 32 bits, passes through the
// record queue and the result register before it reaches the result ports.
// One item is taken every cycle while full is low: the whole window is
// compared in parallel in the front and the back updates its skip counter
// and count for each record it takes. full rises only when the two-entry
// record queue fills because an end-of-text record waits for the previous
// result to be popped. The csr port is always ready; write it only while no
// text is in flight.
module pattern_occurrence_counter #(
   parameter int MAX_PATTERN    = poc_pkg::MAX_PATTERN_DEFAULT,
   parameter int SEGMENT_BUFFER = poc_pkg::SEGMENT_BUFFER_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_byte_present,
   input  logic                            req_end_of_text,
   output logic                            empty,
   input  logic                            pop,
   output logic [31:0]                     rsp_match_count,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [poc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                     csr_wdata
);
   import poc_pkg::*;

   logic [63:0] pattern_low_ff;
   logic [63:0] pattern_high_ff;
   logic [4:0]  pattern_length_ff;
   logic        item_valid;
   logic        q_push;
   logic        q_full;
   logic        q_empty;
   logic        q_pop;
   rec_type     q_in_rec;
   rec_type     q_out_rec;

   // Configuration registers; writes beyond the list are ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= 5'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_wdata;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_wdata;
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // The input side is held off only by the record queue.
   assign full       = q_full;
   assign item_valid = push && !q_full;

   poc_front #(
      .MAX_PATTERN    (MAX_PATTERN),
      .SEGMENT_BUFFER (SEGMENT_BUFFER)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .pattern_low    (pattern_low_ff),
      .pattern_high   (pattern_high_ff),
      .pattern_length (pattern_length_ff),
      .item_valid     (item_valid),
      .data_byte      (req_data_byte),
      .byte_present   (req_byte_present),
      .end_of_text    (req_end_of_text),
      .rec_push       (q_push),
      .rec            (q_in_rec)
   );

   poc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_in_rec),
      .full     (q_full),
      .pop      (q_pop),
      .pop_rec  (q_out_rec),
      .empty    (q_empty)
   );

   poc_back #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pattern_length (pattern_length_ff),
      .rec_valid      (!q_empty),
      .rec            (q_out_rec),
      .rec_take       (q_pop),
      .pop            (pop),
      .empty          (empty),
      .match_count    (rsp_match_count)
   );

   // The front never offers a record to a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("record pushed into a full queue");

   // A taken end-of-text record always produces a waiting result.
   a_eot_gives_result: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_out_rec.eot) |=> !empty)
      else $error("end of text taken without a result");

   // Items with neither a byte nor an end marker leave no record.
   a_empty_item_dropped: assert property (@(posedge clock) disable iff (reset)
      (push && !full && !req_byte_present && !req_end_of_text) |-> !q_push)
      else $error("empty item reached the record queue");

endmodule

`default_nettype wire
